// ===== sv/gtdvs_pkg.sv =====
// gtdvs_pkg: shared types and constants for the geo target distance and visibility scorer
// no dependencies; used by every module of the block

package gtdvs_pkg;

    localparam int CORDIC_STEPS = 31;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 32;
    localparam int XY_W         = 34;
    localparam int ANG_W        = 33;

    localparam logic [29:0] ATAN_UNITS [0:CORDIC_STEPS-1] = '{
        30'd720000000, 30'd425040819, 30'd224579895, 30'd114000262, 30'd57221350,
        30'd28638570,  30'd14322779,  30'd7161827,   30'd3580968,   30'd1790491,
        30'd895246,    30'd447623,    30'd223812,    30'd111906,    30'd55953,
        30'd27976,     30'd13988,     30'd6994,      30'd3497,      30'd1749,
        30'd874,       30'd437,       30'd219,       30'd109,       30'd55,
        30'd27,        30'd14,        30'd7,         30'd3,         30'd2,
        30'd1
    };

    localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [30:0] ONE_Q30 = 31'h40000000;
    localparam logic [30:0] ANG_90  = 31'd1440000000;

    localparam logic [1:0] REG_SENSOR_LAT = 2'd0;
    localparam logic [1:0] REG_SENSOR_LON = 2'd1;
    localparam logic [1:0] REG_SENSOR_ALT = 2'd2;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } sqrt_t;

    typedef struct packed {
        logic [25:0] d;
        logic [25:0] rem;
        logic [31:0] q;
    } div_t;

    typedef struct packed {
        logic [15:0] tag;
        logic        err;
        logic [15:0] talt;
        logic [29:0] term;
        logic [24:0] hsum;
        logic        los;
        logic [24:0] dist_m;
    } side_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [24:0] dist_m;
        logic        los;
        logic [16:0] score;
        logic        err;
    } result_t;

endpackage

// ===== sv/geo_target_distance_visibility_score.sv =====
// geo_target_distance_visibility_score: haversine distance, radio horizon and score
// depends on gtdvs_pkg, gtdvs_cordic_cell, gtdvs_sqrt_cell and gtdvs_div_cell
// one item per cycle sustained while the output buffer is not full
// path: 31 rotation cells, 32 root cells, 31 vectoring cells, 32 divider cells, 7 stages
// a 2-entry output buffer keeps input open while one result waits
// reset clears sensor registers, stage valid bits and the output buffer count

module geo_target_distance_visibility_score (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        target_tag,
    input  logic signed [27:0] target_lat,
    input  logic signed [28:0] target_lon,
    input  logic [15:0]        target_alt,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        result_tag,
    output logic [24:0]        distance_m,
    output logic               line_of_sight,
    output logic [16:0]        score_q16,
    output logic               coord_error
);

    localparam int K_ROT_END = gtdvs_pkg::CORDIC_STEPS;
    localparam int K_M1      = K_ROT_END + 1;
    localparam int K_M2      = K_M1 + 1;
    localparam int K_M3      = K_M2 + 1;
    localparam int K_SQ_END  = K_M3 + gtdvs_pkg::SQRT_STEPS;
    localparam int K_VEC_END = K_SQ_END + gtdvs_pkg::CORDIC_STEPS;
    localparam int K_V1      = K_VEC_END + 1;
    localparam int K_V2      = K_V1 + 1;
    localparam int K_V3      = K_V2 + 1;
    localparam int K_LAST    = K_V3 + gtdvs_pkg::DIV_STEPS;
    localparam int N_STAGES  = K_LAST + 1;

    localparam logic signed [31:0] LAT_LIMIT = 32'sd90000000;
    localparam logic signed [31:0] LON_LIMIT = 32'sd180000000;
    localparam logic signed [34:0] HANG_90   = 35'sd1440000000;
    localparam logic signed [34:0] HANG_180  = 35'sd2880000000;
    localparam logic [25:0] M_PER_UNIT2 = 26'd59697322;
    localparam logic [24:0] DIST_MAX    = 25'd20100000;
    localparam logic [12:0] HOR_SCALE   = 13'd4120;
    localparam logic [10:0] ALT_CAP     = 11'd2000;
    localparam logic [12:0] ALT_FRAC    = 13'd7296;
    localparam logic [15:0] RECIP_10K   = 16'd53687;
    localparam logic [13:0] TEN_K       = 14'd10000;
    localparam logic [18:0] ALT_WHOLE   = 19'd429496;
    localparam logic [25:0] DIST_BIAS   = 26'd50000;
    localparam logic [25:0] SCORE_NUM   = 26'd30000;
    localparam logic [33:0] VIS_TERM    = 34'd858993459;

    // configuration
    logic signed [27:0] sensor_lat_reg;
    logic signed [28:0] sensor_lon_reg;
    logic [15:0]        sensor_alt_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_lat_reg <= '0;
            sensor_lon_reg <= '0;
            sensor_alt_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                gtdvs_pkg::REG_SENSOR_LAT: sensor_lat_reg <= pwdata[27:0];
                gtdvs_pkg::REG_SENSOR_LON: sensor_lon_reg <= pwdata[28:0];
                gtdvs_pkg::REG_SENSOR_ALT: sensor_alt_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            gtdvs_pkg::REG_SENSOR_LAT: prdata = 32'(sensor_lat_reg);
            gtdvs_pkg::REG_SENSOR_LON: prdata = 32'(sensor_lon_reg);
            gtdvs_pkg::REG_SENSOR_ALT: prdata = 32'(sensor_alt_reg);
            default:                   prdata = '0;
        endcase
    end

    // pipeline control
    logic                en;
    logic                push;
    logic                pop;
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] vld_next;
    gtdvs_pkg::side_t    side_reg  [0:N_STAGES-1];
    gtdvs_pkg::side_t    side_next [0:N_STAGES-1];

    assign en       = (cnt_reg != 2'd2);
    assign in_ready = en;
    assign vld_next = {vld_reg[N_STAGES-2:0], in_valid & in_ready};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // input stage
    logic signed [33:0] hlat_w;
    logic signed [34:0] hlon_w;
    logic signed [34:0] hlon_wrap;
    logic               err_in;
    gtdvs_pkg::cordic_t rot0_next [0:3];
    gtdvs_pkg::cordic_t rot0_reg  [0:3];

    always_comb
    begin
        err_in = (32'(sensor_lat_reg) < -LAT_LIMIT) || (32'(sensor_lat_reg) > LAT_LIMIT) ||
                 (32'(sensor_lon_reg) < -LON_LIMIT) || (32'(sensor_lon_reg) > LON_LIMIT) ||
                 (32'(target_lat) < -LAT_LIMIT) || (32'(target_lat) > LAT_LIMIT) ||
                 (32'(target_lon) < -LON_LIMIT) || (32'(target_lon) > LON_LIMIT);
        hlat_w = (34'(target_lat) - 34'(sensor_lat_reg)) <<< 3;
        hlon_w = (35'(target_lon) - 35'(sensor_lon_reg)) <<< 3;
        if (hlon_w > HANG_90)
        begin
            hlon_wrap = hlon_w - HANG_180;
        end
        else if (hlon_w < -HANG_90)
        begin
            hlon_wrap = hlon_w + HANG_180;
        end
        else
        begin
            hlon_wrap = hlon_w;
        end
        for (int l = 0; l < 4; l++)
        begin
            rot0_next[l].x = gtdvs_pkg::CORDIC_X0;
            rot0_next[l].y = '0;
        end
        rot0_next[0].z = hlat_w[32:0];
        rot0_next[1].z = hlon_wrap[32:0];
        rot0_next[2].z = 33'(sensor_lat_reg) <<< 4;
        rot0_next[3].z = 33'(target_lat) <<< 4;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot0_reg <= rot0_next;
        end
    end

    // sin and cos chain, lanes: half lat diff, half lon diff, sensor lat, target lat
    gtdvs_pkg::cordic_t rot_q [0:gtdvs_pkg::CORDIC_STEPS][0:3];

    for (genvar l = 0; l < 4; l++)
    begin : g_rot_lane
        assign rot_q[0][l] = rot0_reg[l];
        for (genvar c = 0; c < gtdvs_pkg::CORDIC_STEPS; c++)
        begin : g_rot_cell
            gtdvs_cordic_cell #(.STEP(c), .VECTOR(1'b0)) u_cell (
                .clk        (clk),
                .advance    (en),
                .upstream   (rot_q[c][l]),
                .downstream (rot_q[c+1][l])
            );
        end
    end

    // haversine term stages
    logic signed [33:0] s_lat;
    logic signed [33:0] s_lon;
    logic signed [33:0] c_s;
    logic signed [33:0] c_t;
    logic [30:0]        abs_lat;
    logic [30:0]        abs_lon;
    logic [30:0]        cs_cl;
    logic [30:0]        ct_cl;
    logic [61:0]        sq_lat;
    logic [61:0]        sq_lon;
    logic [61:0]        cc_prod;
    logic [61:0]        t_prod;
    logic [31:0]        a_sum;
    logic [16:0]        alt_tot;
    logic [10:0]        alt_x;
    logic [39:0]        q1_prod;
    logic [23:0]        q1_back;
    logic [23:0]        alt_r;
    logic [10:0]        alt_q;
    logic [30:0]        m1_sdl_reg;
    logic [30:0]        m1_sdn_reg;
    logic [30:0]        m1_c12_reg;
    logic [10:0]        m1_x_reg;
    logic [23:0]        m1_v_reg;
    logic [30:0]        m2_sdl_reg;
    logic [30:0]        m2_t_reg;
    logic [10:0]        m2_x_reg;
    logic [23:0]        m2_v_reg;
    logic [10:0]        m2_q1_reg;
    logic [30:0]        m3_a_reg;
    logic [30:0]        m1_sdl_next;
    logic [30:0]        m1_sdn_next;
    logic [30:0]        m1_c12_next;
    logic [10:0]        m1_x_next;
    logic [23:0]        m1_v_next;
    logic [30:0]        m2_t_next;
    logic [10:0]        m2_q1_next;
    logic [30:0]        m3_a_next;
    logic [29:0]        term_next;

    always_comb
    begin
        s_lat   = rot_q[K_ROT_END][0].y;
        s_lon   = rot_q[K_ROT_END][1].y;
        c_s     = rot_q[K_ROT_END][2].x;
        c_t     = rot_q[K_ROT_END][3].x;
        abs_lat = (s_lat < 0) ? 31'(-s_lat) : s_lat[30:0];
        abs_lon = (s_lon < 0) ? 31'(-s_lon) : s_lon[30:0];
        sq_lat  = abs_lat * abs_lat;
        sq_lon  = abs_lon * abs_lon;
        m1_sdl_next = (sq_lat[61:30] > 32'(gtdvs_pkg::ONE_Q30)) ?
                      gtdvs_pkg::ONE_Q30 : sq_lat[60:30];
        m1_sdn_next = (sq_lon[61:30] > 32'(gtdvs_pkg::ONE_Q30)) ?
                      gtdvs_pkg::ONE_Q30 : sq_lon[60:30];
        if (c_s < 0)
        begin
            cs_cl = '0;
        end
        else if (c_s > 34'(gtdvs_pkg::ONE_Q30))
        begin
            cs_cl = gtdvs_pkg::ONE_Q30;
        end
        else
        begin
            cs_cl = c_s[30:0];
        end
        if (c_t < 0)
        begin
            ct_cl = '0;
        end
        else if (c_t > 34'(gtdvs_pkg::ONE_Q30))
        begin
            ct_cl = gtdvs_pkg::ONE_Q30;
        end
        else
        begin
            ct_cl = c_t[30:0];
        end
        cc_prod     = cs_cl * ct_cl;
        m1_c12_next = cc_prod[60:30];

        alt_tot   = 17'(sensor_alt_reg) + 17'(side_reg[K_ROT_END].talt);
        alt_x     = (alt_tot > 17'(ALT_CAP)) ? ALT_CAP : alt_tot[10:0];
        m1_x_next = alt_x;
        m1_v_next = alt_x * ALT_FRAC;

        t_prod     = m1_c12_reg * m1_sdn_reg;
        m2_t_next  = t_prod[60:30];
        q1_prod    = m1_v_reg * RECIP_10K;
        m2_q1_next = q1_prod[39:29];

        a_sum     = 32'(m2_sdl_reg) + 32'(m2_t_reg);
        m3_a_next = (a_sum > 32'(gtdvs_pkg::ONE_Q30)) ? gtdvs_pkg::ONE_Q30 : a_sum[30:0];
        q1_back   = m2_q1_reg * TEN_K;
        alt_r     = m2_v_reg - q1_back;
        alt_q     = (alt_r >= 24'(TEN_K)) ? (m2_q1_reg + 11'd1) : m2_q1_reg;
        term_next = (m2_x_reg * ALT_WHOLE) + 30'(alt_q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_sdl_reg <= m1_sdl_next;
            m1_sdn_reg <= m1_sdn_next;
            m1_c12_reg <= m1_c12_next;
            m1_x_reg   <= m1_x_next;
            m1_v_reg   <= m1_v_next;
            m2_sdl_reg <= m1_sdl_reg;
            m2_t_reg   <= m2_t_next;
            m2_x_reg   <= m1_x_reg;
            m2_v_reg   <= m1_v_reg;
            m2_q1_reg  <= m2_q1_next;
            m3_a_reg   <= m3_a_next;
        end
    end

    // root chain, lanes: sqrt(a), sqrt(1-a), sensor alt, target alt
    gtdvs_pkg::sqrt_t sq_q [0:gtdvs_pkg::SQRT_STEPS][0:3];

    assign sq_q[0][0] = '{n: 64'(m3_a_reg) << 30, res: '0};
    assign sq_q[0][1] = '{n: 64'(gtdvs_pkg::ONE_Q30 - m3_a_reg) << 30, res: '0};
    assign sq_q[0][2] = '{n: 64'(sensor_alt_reg) << 32, res: '0};
    assign sq_q[0][3] = '{n: 64'(side_reg[K_M3].talt) << 32, res: '0};

    for (genvar l = 0; l < 4; l++)
    begin : g_sq_lane
        for (genvar c = 0; c < gtdvs_pkg::SQRT_STEPS; c++)
        begin : g_sq_cell
            gtdvs_sqrt_cell #(.STEP(c)) u_cell (
                .clk        (clk),
                .advance    (en),
                .upstream   (sq_q[c][l]),
                .downstream (sq_q[c+1][l])
            );
        end
    end

    // central angle chain
    gtdvs_pkg::cordic_t vec_q [0:gtdvs_pkg::CORDIC_STEPS];

    assign vec_q[0] = '{x: 34'(sq_q[gtdvs_pkg::SQRT_STEPS][1].res[31:0]),
                        y: 34'(sq_q[gtdvs_pkg::SQRT_STEPS][0].res[31:0]),
                        z: '0};

    for (genvar c = 0; c < gtdvs_pkg::CORDIC_STEPS; c++)
    begin : g_vec_cell
        gtdvs_cordic_cell #(.STEP(c), .VECTOR(1'b1)) u_cell (
            .clk        (clk),
            .advance    (en),
            .upstream   (vec_q[c]),
            .downstream (vec_q[c+1])
        );
    end

    // distance and horizon stages
    logic signed [32:0] z_end;
    logic [30:0]        z_cl;
    logic [41:0]        v1_plo_reg;
    logic [40:0]        v1_phi_reg;
    logic [41:0]        v1_plo_next;
    logic [40:0]        v1_phi_next;
    logic [57:0]        v2_prod_reg;
    logic [37:0]        v2_hor_reg;
    logic [57:0]        v2_prod_next;
    logic [37:0]        v2_hor_next;
    logic [57:0]        prod_rnd;
    logic [25:0]        dist_raw;
    logic [24:0]        dist_next;
    logic               los_next;

    always_comb
    begin
        z_end = vec_q[gtdvs_pkg::CORDIC_STEPS].z;
        if (z_end < 0)
        begin
            z_cl = '0;
        end
        else if (z_end > 33'(gtdvs_pkg::ANG_90))
        begin
            z_cl = gtdvs_pkg::ANG_90;
        end
        else
        begin
            z_cl = z_end[30:0];
        end
        v1_plo_next  = z_cl[15:0] * M_PER_UNIT2;
        v1_phi_next  = z_cl[30:16] * M_PER_UNIT2;
        v2_prod_next = {1'b0, v1_phi_reg, 16'b0} + 58'(v1_plo_reg);
        v2_hor_next  = side_reg[K_V1].hsum * HOR_SCALE;
        prod_rnd     = v2_prod_reg + 58'h80000000;
        dist_raw     = prod_rnd[57:32];
        dist_next    = (dist_raw > 26'(DIST_MAX)) ? DIST_MAX : dist_raw[24:0];
        los_next     = (v2_prod_reg[57:16] <= 42'(v2_hor_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_plo_reg  <= v1_plo_next;
            v1_phi_reg  <= v1_phi_next;
            v2_prod_reg <= v2_prod_next;
            v2_hor_reg  <= v2_hor_next;
        end
    end

    // distance score divider chain
    gtdvs_pkg::div_t div_q [0:gtdvs_pkg::DIV_STEPS];

    assign div_q[0] = '{d: DIST_BIAS + 26'(side_reg[K_V3].dist_m), rem: SCORE_NUM, q: '0};

    for (genvar c = 0; c < gtdvs_pkg::DIV_STEPS; c++)
    begin : g_div_cell
        gtdvs_div_cell u_cell (
            .clk        (clk),
            .advance    (en),
            .upstream   (div_q[c]),
            .downstream (div_q[c+1])
        );
    end

    // item side data along the pipeline
    always_comb
    begin
        side_next[0]      = '0;
        side_next[0].tag  = target_tag;
        side_next[0].err  = err_in;
        side_next[0].talt = target_alt;
        for (int k = 1; k < N_STAGES; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[K_M3].term      = term_next;
        side_next[K_SQ_END+1].hsum =
            25'(sq_q[gtdvs_pkg::SQRT_STEPS][2].res[24:0]) +
            25'(sq_q[gtdvs_pkg::SQRT_STEPS][3].res[24:0]);
        side_next[K_V3].dist_m    = dist_next;
        side_next[K_V3].los       = los_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_STAGES; k++)
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // final score and output buffer
    gtdvs_pkg::side_t   fin;
    gtdvs_pkg::result_t res;
    logic [33:0]        score_sum;
    logic [33:0]        score_rnd;
    logic [17:0]        score_raw;
    gtdvs_pkg::result_t skid0_reg;
    gtdvs_pkg::result_t skid1_reg;
    gtdvs_pkg::result_t skid0_next;
    gtdvs_pkg::result_t skid1_next;

    always_comb
    begin
        fin       = side_reg[K_LAST];
        score_sum = 34'(div_q[gtdvs_pkg::DIV_STEPS].q) + 34'(fin.term) +
                    (fin.los ? VIS_TERM : 34'd0);
        score_rnd = score_sum + 34'h8000;
        score_raw = score_rnd[33:16];
        res.tag   = fin.tag;
        res.err   = fin.err;
        if (fin.err)
        begin
            res.dist_m = '0;
            res.los    = 1'b0;
            res.score  = '0;
        end
        else
        begin
            res.dist_m = fin.dist_m;
            res.los    = fin.los;
            res.score  = (score_raw > 18'h10000) ? 17'h10000 : score_raw[16:0];
        end
    end

    assign push = vld_reg[K_LAST] & en;
    assign pop  = out_valid & out_ready;

    always_comb
    begin
        skid0_next = skid0_reg;
        skid1_next = skid1_reg;
        cnt_next   = cnt_reg;
        case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    skid0_next = res;
                end
                else
                begin
                    skid1_next = res;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                skid0_next = skid1_reg;
                cnt_next   = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    skid0_next = res;
                end
                else
                begin
                    skid0_next = skid1_reg;
                    skid1_next = res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skid0_reg <= skid0_next;
        skid1_reg <= skid1_next;
    end

    assign out_valid     = (cnt_reg != 2'd0);
    assign result_tag    = skid0_reg.tag;
    assign distance_m    = skid0_reg.dist_m;
    assign line_of_sight = skid0_reg.los;
    assign score_q16     = skid0_reg.score;
    assign coord_error   = skid0_reg.err;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_full_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input closed with no result pending");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && coord_error) |-> (distance_m == '0 && !line_of_sight && score_q16 == '0))
        else $error("error item carries nonzero results");

    a_score_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (score_q16 <= 17'h10000))
        else $error("score above one");
`endif

endmodule

// ===== sv/gtdvs_cordic_cell.sv =====
// gtdvs_cordic_cell: one micro-rotation of a cordic chain, rotation or vectoring mode
// depends on gtdvs_pkg for the cordic_t type and the arctangent table

module gtdvs_cordic_cell #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                clk,
    input  logic                advance,
    input  gtdvs_pkg::cordic_t  upstream,
    output gtdvs_pkg::cordic_t  downstream
);

    gtdvs_pkg::cordic_t q_reg;
    gtdvs_pkg::cordic_t q_next;

    logic signed [gtdvs_pkg::XY_W-1:0]  x_cur;
    logic signed [gtdvs_pkg::XY_W-1:0]  y_cur;
    logic signed [gtdvs_pkg::ANG_W-1:0] z_cur;
    logic signed [gtdvs_pkg::XY_W-1:0]  x_sh;
    logic signed [gtdvs_pkg::XY_W-1:0]  y_sh;
    logic signed [gtdvs_pkg::ANG_W-1:0] ang;
    logic                               pos;

    always_comb
    begin
        x_cur = upstream.x;
        y_cur = upstream.y;
        z_cur = upstream.z;
        x_sh  = x_cur >>> STEP;
        y_sh  = y_cur >>> STEP;
        ang   = $signed({3'b000, gtdvs_pkg::ATAN_UNITS[STEP]});
        pos   = VECTOR ? (y_cur < 0) : (z_cur >= 0);
        if (pos)
        begin
            q_next.x = x_cur - y_sh;
            q_next.y = y_cur + x_sh;
            q_next.z = z_cur - ang;
        end
        else
        begin
            q_next.x = x_cur + y_sh;
            q_next.y = y_cur - x_sh;
            q_next.z = z_cur + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q_reg <= q_next;
        end
    end

    assign downstream = q_reg;

endmodule

// ===== sv/gtdvs_sqrt_cell.sv =====
// gtdvs_sqrt_cell: one bit of a digit-by-digit integer square root chain
// depends on gtdvs_pkg for the sqrt_t type

module gtdvs_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              advance,
    input  gtdvs_pkg::sqrt_t  upstream,
    output gtdvs_pkg::sqrt_t  downstream
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    gtdvs_pkg::sqrt_t q_reg;
    gtdvs_pkg::sqrt_t q_next;
    logic [63:0]      trial;

    always_comb
    begin
        trial = upstream.res + BIT;
        if (upstream.n >= trial)
        begin
            q_next.n   = upstream.n - trial;
            q_next.res = (upstream.res >> 1) + BIT;
        end
        else
        begin
            q_next.n   = upstream.n;
            q_next.res = upstream.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q_reg <= q_next;
        end
    end

    assign downstream = q_reg;

endmodule

// ===== sv/gtdvs_div_cell.sv =====
// gtdvs_div_cell: one quotient bit of a restoring divider chain
// depends on gtdvs_pkg for the div_t type

module gtdvs_div_cell (
    input  logic             clk,
    input  logic             advance,
    input  gtdvs_pkg::div_t  upstream,
    output gtdvs_pkg::div_t  downstream
);

    gtdvs_pkg::div_t q_reg;
    gtdvs_pkg::div_t q_next;
    logic [26:0]     rem2;
    logic [26:0]     diff;

    always_comb
    begin
        rem2     = {upstream.rem, 1'b0};
        diff     = rem2 - {1'b0, upstream.d};
        q_next.d = upstream.d;
        if (rem2 >= {1'b0, upstream.d})
        begin
            q_next.rem = diff[25:0];
            q_next.q   = {upstream.q[30:0], 1'b1};
        end
        else
        begin
            q_next.rem = rem2[25:0];
            q_next.q   = {upstream.q[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q_reg <= q_next;
        end
    end

    assign downstream = q_reg;

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for geo_target_distance_visibility_score, haversine distance scorer
// depends on gtdvs_pkg and the block; directed table then random phases checked by a predictor
`timescale 1ns / 100ps

module tb;

    typedef struct {
        bit [15:0] tag;
        bit [24:0] dist_m;
        bit        los;
        bit [16:0] score;
        bit        err;
    } geo_result_t;

    typedef struct {
        bit [15:0]        tag;
        longint           lat;
        longint           lon;
        bit [15:0]        alt;
        bit               typed;
        bit [24:0]        dist_m;
        bit               los;
        bit [16:0]        score;
        bit               err;
    } stim_row_t;

    localparam int N_DIRECTED = 19;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [15:0]        target_tag;
    logic signed [27:0] target_lat;
    logic signed [28:0] target_lon;
    logic [15:0]        target_alt;
    logic               out_valid;
    logic               out_ready;
    logic [15:0]        result_tag;
    logic [24:0]        distance_m;
    logic               line_of_sight;
    logic [16:0]        score_q16;
    logic               coord_error;

    longint      sensor_lat_q;
    longint      sensor_lon_q;
    longint      sensor_alt_q;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          error_count;
    geo_result_t pending_results[$];

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{16'h0000, 0, 0, 16'd0, 0, 0, 0, 0, 0},
        '{16'hffff, 0, 0, 16'hffff, 0, 0, 0, 0, 0},
        '{16'h0001, 90000000, 0, 16'd0, 0, 0, 0, 0, 0},
        '{16'h0002, -90000000, 0, 16'd0, 0, 0, 0, 0, 0},
        '{16'h0003, 0, 180000000, 16'd0, 0, 0, 0, 0, 0},
        '{16'h0004, 0, -180000000, 16'd65535, 0, 0, 0, 0, 0},
        '{16'h0005, 1000, 0, 16'd100, 0, 0, 0, 0, 0},
        '{16'h0006, 45000000, 90000000, 16'd300, 0, 0, 0, 0, 0},
        '{16'h0007, -45000000, -135000000, 16'd2000, 0, 0, 0, 0, 0},
        '{16'h0008, 0, 1, 16'd1, 0, 0, 0, 0, 0},
        '{16'h0009, 90000001, 0, 16'd0, 1, 25'd0, 1'b0, 17'd0, 1'b1},
        '{16'h000a, -90000001, 0, 16'd0, 1, 25'd0, 1'b0, 17'd0, 1'b1},
        '{16'h000b, 134217727, 0, 16'd5, 1, 25'd0, 1'b0, 17'd0, 1'b1},
        '{16'h000c, -134217728, 0, 16'd5, 1, 25'd0, 1'b0, 17'd0, 1'b1},
        '{16'h000d, 0, 180000001, 16'd0, 1, 25'd0, 1'b0, 17'd0, 1'b1},
        '{16'h000e, 0, -180000001, 16'd0, 1, 25'd0, 1'b0, 17'd0, 1'b1},
        '{16'h000f, 0, 268435455, 16'd0, 1, 25'd0, 1'b0, 17'd0, 1'b1},
        '{16'h5a5a, 0, -268435456, 16'd0, 1, 25'd0, 1'b0, 17'd0, 1'b1},
        '{16'ha5a5, 89999999, 179999999, 16'd65534, 0, 0, 0, 0, 0}
    };

    geo_target_distance_visibility_score dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .target_tag    (target_tag),
        .target_lat    (target_lat),
        .target_lon    (target_lon),
        .target_alt    (target_alt),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_tag    (result_tag),
        .distance_m    (distance_m),
        .line_of_sight (line_of_sight),
        .score_q16     (score_q16),
        .coord_error   (coord_error)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void cordic_rotate(input longint theta, output longint c,
                                          output longint s);
        longint x;
        longint y;
        longint z;
        longint nx;
        x = longint'(gtdvs_pkg::CORDIC_X0);
        y = 0;
        z = theta;
        for (int i = 0; i < gtdvs_pkg::CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(gtdvs_pkg::ATAN_UNITS[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(gtdvs_pkg::ATAN_UNITS[i]);
            end
            x = nx;
        end
        c = x;
        s = y;
    endfunction

    function automatic longint cordic_vector_angle(input longint x0, input longint y0);
        longint x;
        longint y;
        longint z;
        longint nx;
        x = x0;
        y = y0;
        z = 0;
        for (int i = 0; i < gtdvs_pkg::CORDIC_STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(gtdvs_pkg::ATAN_UNITS[i]);
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(gtdvs_pkg::ATAN_UNITS[i]);
            end
            x = nx;
        end
        if (z < 0)
            z = 0;
        if (z > longint'(gtdvs_pkg::ANG_90))
            z = longint'(gtdvs_pkg::ANG_90);
        return z;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v < 0)
            return 0;
        if (v > longint'(gtdvs_pkg::ONE_Q30))
            return longint'(gtdvs_pkg::ONE_Q30);
        return v;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned n0);
        longint unsigned n;
        longint unsigned res;
        longint unsigned b;
        n   = n0;
        res = 0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= res + b)
            begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic geo_result_t score_target(input bit [15:0] tag,
                                                 input bit signed [27:0] lat_b,
                                                 input bit signed [28:0] lon_b,
                                                 input bit [15:0] alt);
        geo_result_t     r;
        longint          tlat;
        longint          tlon;
        longint          hlat;
        longint          hlon;
        longint          c;
        longint          s;
        longint          sdl;
        longint          sdn;
        longint          c1;
        longint          c2;
        longint          c12;
        longint          a;
        longint          ra;
        longint          rb;
        longint          z;
        longint unsigned prod;
        longint unsigned dist_m;
        longint unsigned hor;
        longint unsigned alt_sum;
        longint unsigned sum;
        longint unsigned score;
        bit              los;
        tlat     = lat_b;
        tlon     = lon_b;
        r.tag    = tag;
        r.dist_m = '0;
        r.los    = 1'b0;
        r.score  = '0;
        r.err    = 1'b0;
        if (sensor_lat_q < -90000000 || sensor_lat_q > 90000000 ||
            sensor_lon_q < -180000000 || sensor_lon_q > 180000000 ||
            tlat < -90000000 || tlat > 90000000 ||
            tlon < -180000000 || tlon > 180000000)
        begin
            r.err = 1'b1;
            return r;
        end
        hlat = (tlat - sensor_lat_q) * 8;
        hlon = (tlon - sensor_lon_q) * 8;
        if (hlon > longint'(gtdvs_pkg::ANG_90))
            hlon = hlon - 2 * longint'(gtdvs_pkg::ANG_90);
        else if (hlon < -longint'(gtdvs_pkg::ANG_90))
            hlon = hlon + 2 * longint'(gtdvs_pkg::ANG_90);
        cordic_rotate(hlat, c, s);
        sdl = clamp_unit((s * s) >>> 30);
        cordic_rotate(hlon, c, s);
        sdn = clamp_unit((s * s) >>> 30);
        cordic_rotate(sensor_lat_q * 16, c, s);
        c1 = clamp_unit(c);
        cordic_rotate(tlat * 16, c, s);
        c2 = clamp_unit(c);
        c12 = (c1 * c2) >>> 30;
        a   = clamp_unit(sdl + ((c12 * sdn) >>> 30));
        ra  = longint'(root_floor(longint'(a) << 30));
        rb  = longint'(root_floor(longint'(longint'(gtdvs_pkg::ONE_Q30) - a) << 30));
        z   = cordic_vector_angle(rb, ra);
        prod = longint'(z) * 2 * 64'd29848661;
        dist_m = (prod + (64'd1 << 31)) >> 32;
        if (dist_m > 64'd20100000)
            dist_m = 64'd20100000;
        hor = 64'd4120 * (root_floor(longint'(sensor_alt_q) << 32) +
                          root_floor(longint'(alt) << 32));
        los = (prod >> 16) <= hor;
        alt_sum = sensor_alt_q + alt;
        if (alt_sum > 2000)
            alt_sum = 2000;
        sum = (64'd30000 << 32) / (64'd50000 + dist_m);
        sum = sum + (alt_sum << 32) / 64'd10000;
        if (los)
            sum = sum + 64'd858993459;
        score = (sum + (64'd1 << 15)) >> 16;
        if (score > 65536)
            score = 65536;
        r.dist_m = dist_m[24:0];
        r.los    = los;
        r.score  = score[16:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic write_register(input logic [1:0] idx, input longint value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value[31:0];
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            gtdvs_pkg::REG_SENSOR_LAT: sensor_lat_q = longint'($signed(value[27:0]));
            gtdvs_pkg::REG_SENSOR_LON: sensor_lon_q = longint'($signed(value[28:0]));
            gtdvs_pkg::REG_SENSOR_ALT: sensor_alt_q = longint'(value[15:0]);
            default: ;
        endcase
    endtask

    task automatic set_sensor(input longint lat, input longint lon, input longint alt);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        write_register(gtdvs_pkg::REG_SENSOR_LAT, lat);
        write_register(gtdvs_pkg::REG_SENSOR_LON, lon);
        write_register(gtdvs_pkg::REG_SENSOR_ALT, alt);
    endtask

    task automatic send_target(input bit [15:0] tag, input bit [27:0] lat, input bit [28:0] lon,
                               input bit [15:0] alt, input bit typed, input geo_result_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        target_tag <= tag;
        target_lat <= lat;
        target_lon <= lon;
        target_alt <= alt;
        do
            @(posedge clk);
        while (!in_ready);
        if (typed)
            pending_results.insert(pending_results.size(), want);
        else
            pending_results.insert(pending_results.size(), score_target(tag, lat, lon, alt));
    endtask

    task automatic send_random_targets(input int count);
        bit [27:0]   lat;
        bit [28:0]   lon;
        bit [15:0]   alt;
        int          pick;
        longint      v;
        geo_result_t none;
        none = '{default: 0};
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                lat = 28'($urandom);
                lon = 29'($urandom);
            end
            else if (pick < 40)
            begin
                v   = sensor_lat_q + longint'($urandom_range(0, 400000)) - 200000;
                lat = v[27:0];
                v   = sensor_lon_q + longint'($urandom_range(0, 400000)) - 200000;
                lon = v[28:0];
            end
            else
            begin
                v   = longint'($urandom_range(0, 180000000)) - 90000000;
                lat = v[27:0];
                v   = longint'($urandom_range(0, 360000000)) - 180000000;
                lon = v[28:0];
            end
            if ($urandom_range(0, 3) == 0)
                alt = 16'($urandom);
            else
                alt = 16'($urandom_range(0, 2000));
            send_target(16'($urandom), lat, lon, alt, 1'b0, none);
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        geo_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, tag", result_tag, -1);
            else
            begin
                want = pending_results.pop_front();
                if (result_tag != want.tag)
                    report_mismatch("result_tag", result_tag, want.tag);
                if (distance_m != want.dist_m)
                    report_mismatch("distance_m", distance_m, want.dist_m);
                if (line_of_sight != want.los)
                    report_mismatch("line_of_sight", line_of_sight, want.los);
                if (score_q16 != want.score)
                    report_mismatch("score_q16", score_q16, want.score);
                if (coord_error != want.err)
                    report_mismatch("coord_error", coord_error, want.err);
            end
        end
    end

    initial
    begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        geo_result_t want;
        stim_row_t   row;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        target_tag     = '0;
        target_lat     = '0;
        target_lon     = '0;
        target_alt     = '0;
        sensor_lat_q   = 0;
        sensor_lon_q   = 0;
        sensor_alt_q   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < N_DIRECTED; k++)
        begin
            row  = directed_rows[k];
            want = '{row.tag, row.dist_m, row.los, row.score, row.err};
            send_target(row.tag, row.lat[27:0], row.lon[28:0], row.alt, row.typed, want);
        end
        send_random_targets(100);

        set_sensor(45000000, 90000000, 100);
        send_idle_pct = 68;
        send_random_targets(160);

        set_sensor(-90000000, -180000000, 0);
        send_idle_pct  = 0;
        recv_stall_pct = 68;
        send_random_targets(160);

        set_sensor(90000000, 180000000, 65535);
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        send_random_targets(160);

        set_sensor(134217727, -268435456, 40);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_targets(30);

        set_sensor(-1, -179999999, 30);
        send_idle_pct  = 68;
        recv_stall_pct = 68;
        send_random_targets(150);

        set_sensor(12345678, -98765432, 1500);
        send_idle_pct  = 7;
        recv_stall_pct = 68;
        send_random_targets(170);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
